[design/ksem_pkg.sv]
`default_nettype none
package ksem_pkg;

    localparam int NUM_ENTRIES      = 16;
    localparam int HANDLES_PER_PROC = 8;
    localparam int NUM_PROCS        = 8;
    localparam int OPEN_SLOTS       = NUM_PROCS * HANDLES_PER_PROC;

    localparam int ENTRY_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int HND_W    = (HANDLES_PER_PROC > 1) ? $clog2(HANDLES_PER_PROC) : 1;
    localparam int SLOT_W   = (OPEN_SLOTS > 1) ? $clog2(OPEN_SLOTS) : 1;

    localparam int FUNC_W   = 3;
    localparam int PID_W    = 3;
    localparam int KEY_W    = 16;
    localparam int COUNT_W  = 16;
    localparam int HIN_W    = 4;
    localparam int REFS_W   = 7;
    localparam int STATUS_W = 3;
    localparam int NH_W     = 3;
    localparam int WENT_W   = 4;

    localparam logic [FUNC_W-1:0] FN_CREATE = 3'd0;
    localparam logic [FUNC_W-1:0] FN_GET    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_WAIT   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SIGNAL = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLOSE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_HANDLE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_KEY_EXISTS  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_WOULD_BLOCK = 3'd6;

    localparam logic [REFS_W-1:0]  REFS_MAX  = 7'd127;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic               load_req;
        logic               hchk;
        logic               scan_vld;
        logic [ENTRY_W-1:0] scan_idx;
        logic               decide;
        logic               exec;
        logic               out_load;
    } ksem_cmd_t;

    typedef struct packed {
        logic alloc_op;
        logic handle_op;
        logic hchk_fail;
        logic out_busy;
    } ksem_sts_t;

endpackage
`default_nettype wire

[design/ksem_ctrl.sv]
`default_nettype none
module ksem_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ksem_pkg::ksem_sts_t sts,
    output ksem_pkg::ksem_cmd_t cmd
);
    import ksem_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HCHK,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_OREAD,
        S_EXEC,
        S_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [ENTRY_W-1:0] scan_idx_reg, scan_idx_next;

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_HCHK;
                end
            end
            S_HCHK:
            begin
                cmd.hchk = 1'b1;
                priority if (sts.hchk_fail || !(sts.alloc_op || sts.handle_op))
                    state_next = S_RESULT;
                else if (sts.alloc_op)
                begin
                    scan_idx_next = '0;
                    state_next    = S_SCAN;
                end
                else
                    state_next = S_OREAD;
            end
            S_SCAN:
            begin
                cmd.scan_vld = 1'b1;
                cmd.scan_idx = scan_idx_reg;
                if (scan_idx_reg == ENTRY_W'(NUM_ENTRIES - 1))
                    state_next = S_DRAIN;
                else
                    scan_idx_next = scan_idx_reg + 1'b1;
            end
            S_DRAIN:  state_next = S_DECIDE;
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_RESULT;
            end
            S_OREAD:  state_next = S_EXEC;
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

endmodule
`default_nettype wire

[design/ksem_dp.sv]
`default_nettype none
module ksem_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ksem_pkg::ksem_cmd_t            cmd,
    output ksem_pkg::ksem_sts_t            sts,
    input  logic [ksem_pkg::FUNC_W-1:0]    func,
    input  logic [ksem_pkg::PID_W-1:0]     proc_id,
    input  logic [ksem_pkg::KEY_W-1:0]     sem_key,
    input  logic [ksem_pkg::COUNT_W-1:0]   init_count,
    input  logic [ksem_pkg::HIN_W-1:0]     handle,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [ksem_pkg::STATUS_W-1:0]  status,
    output logic [ksem_pkg::NH_W-1:0]      new_handle,
    output logic                           wake,
    output logic [ksem_pkg::WENT_W-1:0]    wake_entry
);
    import ksem_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [REFS_W-1:0]  refs;
    } ent_word_t;

    // request beat
    logic [FUNC_W-1:0]  func_reg;
    logic [PID_W-1:0]   pid_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [COUNT_W-1:0] init_reg;
    logic [HIN_W-1:0]   hin_reg;

    logic [NUM_ENTRIES-1:0] used_reg;
    logic [OPEN_SLOTS-1:0]  open_valid_reg;

    ent_word_t          ent_mem [NUM_ENTRIES];
    ent_word_t          ent_rdata_reg;
    logic [ENTRY_W-1:0] oe_mem [OPEN_SLOTS];
    logic [ENTRY_W-1:0] oe_rdata_reg;

    logic               pv_reg;
    logic [ENTRY_W-1:0] pidx_reg;
    logic               found_reg;
    logic [ENTRY_W-1:0] found_idx_reg;
    ent_word_t          found_word_reg;
    logic               free_found_reg;
    logic [ENTRY_W-1:0] free_idx_reg;
    logic [HND_W-1:0]   hfree_idx_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [NH_W-1:0]     res_nh_reg;
    logic                res_wake_reg;
    logic [WENT_W-1:0]   res_went_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [NH_W-1:0]     out_nh_reg;
    logic                out_wake_reg;
    logic [WENT_W-1:0]   out_went_reg;

    logic                        pid_ok;
    logic [SLOT_W-1:0]           base;
    logic [HANDLES_PER_PROC-1:0] hvec;
    logic                        hfree_any;
    logic [HND_W-1:0]            hfree_idx;
    logic [SLOT_W-1:0]           hslot;
    logic [SLOT_W-1:0]           alloc_slot;
    logic                        hnd_ok;
    logic                        alloc_op;
    logic                        handle_op;
    logic [ENTRY_W-1:0]          ent_raddr;
    logic                        hit;

    logic                ent_we;
    logic [ENTRY_W-1:0]  ent_waddr;
    ent_word_t           ent_wdata;
    logic                used_we;
    logic                used_val;
    logic                ov_we;
    logic [SLOT_W-1:0]   ov_slot;
    logic                ov_val;
    logic                oe_we;
    logic                grant;
    logic [REFS_W-1:0]   refs_dec;
    logic                res_ld;
    logic [STATUS_W-1:0] st_n;
    logic [NH_W-1:0]     nh_n;
    logic                wk_n;
    logic [WENT_W-1:0]   went_n;

    assign pid_ok     = int'(pid_reg) < NUM_PROCS;
    assign base       = SLOT_W'(pid_reg) * SLOT_W'(HANDLES_PER_PROC);
    assign hvec       = pid_ok ? open_valid_reg[base +: HANDLES_PER_PROC] : '1;
    assign hslot      = base + SLOT_W'(hin_reg);
    assign alloc_slot = base + SLOT_W'(hfree_idx_reg);
    assign hnd_ok     = pid_ok && (int'(hin_reg) < HANDLES_PER_PROC)
                        && open_valid_reg[hslot];
    assign alloc_op   = (func_reg == FN_CREATE) || (func_reg == FN_GET);
    assign handle_op  = (func_reg == FN_WAIT) || (func_reg == FN_SIGNAL)
                        || (func_reg == FN_CLOSE);
    assign ent_raddr  = cmd.scan_vld ? cmd.scan_idx : oe_rdata_reg;
    assign hit        = pv_reg && used_reg[pidx_reg] && (ent_rdata_reg.key == key_reg);

    always_comb
    begin
        hfree_any = 1'b0;
        hfree_idx = '0;
        for (int h = HANDLES_PER_PROC - 1; h >= 0; h--)
        begin
            if (!hvec[h])
            begin
                hfree_any = 1'b1;
                hfree_idx = HND_W'(h);
            end
        end
    end

    assign sts.alloc_op  = alloc_op;
    assign sts.handle_op = handle_op;
    assign sts.hchk_fail = alloc_op ? !hfree_any : (handle_op && !hnd_ok);
    assign sts.out_busy  = out_valid_reg && !out_ready;

    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = oe_rdata_reg;
        ent_wdata = ent_rdata_reg;
        used_we   = 1'b0;
        used_val  = 1'b0;
        ov_we     = 1'b0;
        ov_slot   = hslot;
        ov_val    = 1'b0;
        oe_we     = 1'b0;
        grant     = 1'b0;
        refs_dec  = ent_rdata_reg.refs;
        res_ld    = 1'b0;
        st_n      = ST_OK;
        nh_n      = '0;
        wk_n      = 1'b0;
        went_n    = '0;

        if (cmd.hchk)
        begin
            res_ld = 1'b1;
            if (sts.hchk_fail)
                st_n = alloc_op ? ST_NO_HANDLE : ST_BAD_HANDLE;
        end

        if (cmd.decide)
        begin
            res_ld = 1'b1;
            if (func_reg == FN_CREATE)
            begin
                priority if (found_reg)
                    st_n = ST_KEY_EXISTS;
                else if (!free_found_reg)
                    st_n = ST_TABLE_FULL;
                else
                begin
                    ent_we    = 1'b1;
                    ent_waddr = free_idx_reg;
                    ent_wdata = '{key: key_reg, count: init_reg, refs: REFS_W'(1)};
                    used_we   = 1'b1;
                    used_val  = 1'b1;
                    grant     = 1'b1;
                end
            end
            else
            begin
                priority if (!found_reg)
                    st_n = ST_NOT_FOUND;
                else if (found_word_reg.refs >= REFS_MAX)
                    st_n = ST_TABLE_FULL;
                else
                begin
                    ent_we         = 1'b1;
                    ent_waddr      = found_idx_reg;
                    ent_wdata      = found_word_reg;
                    ent_wdata.refs = found_word_reg.refs + 1'b1;
                    grant          = 1'b1;
                end
            end
            if (grant)
            begin
                ov_we   = 1'b1;
                ov_slot = alloc_slot;
                ov_val  = 1'b1;
                oe_we   = 1'b1;
                nh_n    = NH_W'(hfree_idx_reg);
            end
        end

        if (cmd.exec)
        begin
            res_ld = 1'b1;
            if (int'(oe_rdata_reg) >= NUM_ENTRIES)
                st_n = ST_BAD_HANDLE;
            else
            begin
                unique case (func_reg)
                    FN_WAIT:
                    begin
                        if (ent_rdata_reg.count == '0)
                            st_n = ST_WOULD_BLOCK;
                        else
                        begin
                            ent_we          = 1'b1;
                            ent_wdata.count = ent_rdata_reg.count - 1'b1;
                        end
                    end
                    FN_SIGNAL:
                    begin
                        if (ent_rdata_reg.count != COUNT_MAX)
                        begin
                            ent_we          = 1'b1;
                            ent_wdata.count = ent_rdata_reg.count + 1'b1;
                            if (ent_rdata_reg.count == '0)
                            begin
                                wk_n   = 1'b1;
                                went_n = WENT_W'(oe_rdata_reg);
                            end
                        end
                    end
                    FN_CLOSE:
                    begin
                        ov_we = 1'b1;
                        if (ent_rdata_reg.refs != '0)
                            refs_dec = ent_rdata_reg.refs - 1'b1;
                        ent_we         = 1'b1;
                        ent_wdata.refs = refs_dec;
                        if (refs_dec == '0)
                        begin
                            ent_wdata.count = '0;
                            used_we         = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            open_valid_reg <= '0;
            pv_reg         <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.scan_vld;
            if (used_we)
                used_reg[ent_waddr] <= used_val;
            if (ov_we)
                open_valid_reg[ov_slot] <= ov_val;
            if (cmd.hchk)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (pv_reg)
            begin
                if (hit && !found_reg)
                    found_reg <= 1'b1;
                if (!used_reg[pidx_reg] && !free_found_reg)
                    free_found_reg <= 1'b1;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= func;
            pid_reg  <= proc_id;
            key_reg  <= sem_key;
            init_reg <= init_count;
            hin_reg  <= handle;
        end
        if (cmd.hchk)
            hfree_idx_reg <= hfree_idx;

        pidx_reg      <= cmd.scan_idx;
        ent_rdata_reg <= ent_mem[ent_raddr];
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;

        oe_rdata_reg <= oe_mem[hslot];
        if (oe_we)
            oe_mem[alloc_slot] <= ent_waddr;

        if (pv_reg && !cmd.hchk)
        begin
            if (hit && !found_reg)
            begin
                found_idx_reg  <= pidx_reg;
                found_word_reg <= ent_rdata_reg;
            end
            if (!used_reg[pidx_reg] && !free_found_reg)
                free_idx_reg <= pidx_reg;
        end

        if (res_ld)
        begin
            res_status_reg <= st_n;
            res_nh_reg     <= nh_n;
            res_wake_reg   <= wk_n;
            res_went_reg   <= went_n;
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_nh_reg     <= res_nh_reg;
            out_wake_reg   <= res_wake_reg;
            out_went_reg   <= res_went_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign new_handle = out_nh_reg;
    assign wake       = out_wake_reg;
    assign wake_entry = out_went_reg;

endmodule
`default_nettype wire

[design/keyed_semaphore_table_core.sv]
// Keyed semaphore table: a global table of counting semaphores with a handle
// table per process. One request beat (func, proc_id, sem_key, init_count,
// handle) on the in channel gives one result beat (status, new_handle, wake,
// wake_entry) on the out channel; both channels are valid/ready.
// Requests are handled one at a time. in_ready is high only while idle.
// Steps from request beat to out_valid:
//   create, get         key and free-entry scan of every entry through the
//                       entry RAM read port, then the decision
//   wait, signal, close handle RAM read, entry RAM read, update
//   unknown func or failed handle check  straight to the result
// Results go through an output register: if the receiver stalls, the block
// holds the finished result there; the next request is still taken, but its
// result waits in the result state until the output register is free.
// Reset clears all entry-used and handle-open flags and the output valid;
// no clearing pass is needed, the block is ready right after reset.
`default_nettype none
module keyed_semaphore_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ksem_pkg::FUNC_W-1:0]    func,
    input  logic [ksem_pkg::PID_W-1:0]     proc_id,
    input  logic [ksem_pkg::KEY_W-1:0]     sem_key,
    input  logic [ksem_pkg::COUNT_W-1:0]   init_count,
    input  logic [ksem_pkg::HIN_W-1:0]     handle,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ksem_pkg::STATUS_W-1:0]  status,
    output logic [ksem_pkg::NH_W-1:0]      new_handle,
    output logic                           wake,
    output logic [ksem_pkg::WENT_W-1:0]    wake_entry
);
    import ksem_pkg::*;

    ksem_cmd_t cmd;
    ksem_sts_t sts;

    ksem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ksem_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .func       (func),
        .proc_id    (proc_id),
        .sem_key    (sem_key),
        .init_count (init_count),
        .handle     (handle),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .status     (status),
        .new_handle (new_handle),
        .wake       (wake),
        .wake_entry (wake_entry)
    );

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request beat taken but controller stayed idle");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result beat appeared without a request in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_WOULD_BLOCK))
        else $error("status code out of range");

    a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wake) |-> (status == ST_OK))
        else $error("wake reported on a failed request");

    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (new_handle != '0)) |-> (status == ST_OK) && !wake)
        else $error("handle granted on a failed request");
`endif

endmodule
`default_nettype wire
